// File: src/des_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// des_pkg
// Shared types, codes and CiA402 constants for the drive enable sequencer.
// ----------------------------------------------------------------------------
package des_pkg;

  // control words
  localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;
  localparam logic [15:0] CW_SHUTDOWN        = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON       = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP       = 16'h000F;
  localparam logic [15:0] CW_FAULT_RESET     = 16'h0080;

  // status word
  localparam logic [15:0] SW_FAULT       = 16'h0008;
  localparam logic [15:0] SW_STATE_MASK  = 16'h006F;
  localparam logic [15:0] SW_READY       = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED  = 16'h0027;

  // operations
  localparam logic OP_START    = 1'b0;
  localparam logic OP_EXCHANGE = 1'b1;

  // phase codes as seen on the result channel
  localparam logic [2:0] PHC_IDLE   = 3'd0;
  localparam logic [2:0] PHC_PROBE  = 3'd1;
  localparam logic [2:0] PHC_RESET  = 3'd2;
  localparam logic [2:0] PHC_SHUT   = 3'd3;
  localparam logic [2:0] PHC_SWON   = 3'd4;
  localparam logic [2:0] PHC_ENABLE = 3'd5;

  // outcome codes
  localparam logic [2:0] OC_NONE       = 3'd0;
  localparam logic [2:0] OC_ENABLED    = 3'd1;
  localparam logic [2:0] OC_RESET_TO   = 3'd2;
  localparam logic [2:0] OC_STEP_TO    = 3'd3;
  localparam logic [2:0] OC_PERSISTENT = 3'd4;

  // register indexes
  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_ATTEMPTS = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;
  localparam logic [3:0]  ATTEMPTS_RESET = 4'd2;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_PROBE  = 6'b000010,
    PH_RESET  = 6'b000100,
    PH_SHUT   = 6'b001000,
    PH_SWON   = 6'b010000,
    PH_ENABLE = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] command_word;
    logic [15:0] wait_count;
    logic [3:0]  attempt;
    logic [2:0]  outcome;
  } seq_state_t;

  typedef struct packed {
    logic [15:0] timeout_cycles;
    logic [3:0]  max_attempts;
  } seq_cfg_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:   code = PHC_IDLE;
      PH_PROBE:  code = PHC_PROBE;
      PH_RESET:  code = PHC_RESET;
      PH_SHUT:   code = PHC_SHUT;
      PH_SWON:   code = PHC_SWON;
      PH_ENABLE: code = PHC_ENABLE;
      default:   code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// File: src/des_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// des_step
// Next-state logic: applies one start or exchange request to the sequence
// state.
// ----------------------------------------------------------------------------
module des_step
  import des_pkg::*;
(
  input  wire seq_state_t  cur,
  input  wire seq_cfg_t    cfg,
  input  wire logic        operation,
  input  wire logic [15:0] status_word,
  output seq_state_t       nxt
);

  logic [15:0] wait_inc;
  logic        expired;
  logic        fault;
  logic [15:0] masked;
  logic [15:0] target;

  assign wait_inc = cur.wait_count + 16'd1;
  // a zero timeout behaves like one, and a wrapped counter always expires
  assign expired  = (wait_inc >= cfg.timeout_cycles) || (wait_inc == 16'd0);
  assign fault    = (status_word & SW_FAULT) != 16'd0;
  assign masked   = status_word & SW_STATE_MASK;

  always_comb begin
    target = SW_OP_ENABLED;
    if (cur.phase == PH_SHUT) begin
      target = SW_READY;
    end else if (cur.phase == PH_SWON) begin
      target = SW_SWITCHED_ON;
    end
  end

  always_comb begin
    nxt = cur;
    if (operation == OP_START) begin
      nxt.wait_count = 16'd0;
      if (cfg.max_attempts == 4'd0) begin
        nxt.phase   = PH_IDLE;
        nxt.attempt = 4'd0;
        nxt.outcome = OC_PERSISTENT;
      end else begin
        nxt.phase   = PH_PROBE;
        nxt.attempt = 4'd1;
        nxt.outcome = OC_NONE;
      end
    end else begin
      unique case (cur.phase)
        PH_PROBE: begin
          nxt.wait_count = 16'd0;
          if (fault) begin
            nxt.phase        = PH_RESET;
            nxt.command_word = CW_FAULT_RESET;
          end else begin
            nxt.phase        = PH_SHUT;
            nxt.command_word = CW_SHUTDOWN;
          end
        end
        PH_RESET: begin
          if (!fault) begin
            nxt.phase        = PH_SHUT;
            nxt.command_word = CW_SHUTDOWN;
            nxt.wait_count   = 16'd0;
          end else begin
            nxt.wait_count = wait_inc;
            if (expired) begin
              nxt.phase        = PH_IDLE;
              nxt.command_word = CW_DISABLE_VOLTAGE;
              nxt.outcome      = OC_RESET_TO;
            end
          end
        end
        PH_SHUT, PH_SWON, PH_ENABLE: begin
          priority if (masked == target) begin
            nxt.wait_count = 16'd0;
            if (cur.phase == PH_SHUT) begin
              nxt.phase        = PH_SWON;
              nxt.command_word = CW_SWITCH_ON;
            end else if (cur.phase == PH_SWON) begin
              nxt.phase        = PH_ENABLE;
              nxt.command_word = CW_ENABLE_OP;
            end else begin
              nxt.phase      = PH_IDLE;
              nxt.wait_count = cur.wait_count;
              nxt.outcome    = OC_ENABLED;
            end
          end else if (fault) begin
            if (cur.attempt < cfg.max_attempts) begin
              nxt.attempt    = cur.attempt + 4'd1;
              nxt.phase      = PH_PROBE;
              nxt.wait_count = 16'd0;
            end else begin
              nxt.phase   = PH_IDLE;
              nxt.outcome = OC_PERSISTENT;
            end
          end else begin
            nxt.wait_count = wait_inc;
            if (expired) begin
              nxt.phase   = PH_IDLE;
              nxt.outcome = OC_STEP_TO;
            end
          end
        end
        default: begin
          // exchange while idle leaves everything as it is
          nxt = cur;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/drive_enable_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drive_enable_sequencer
// CiA402 bring-up sequencer: probe, fault reset, shutdown, switch on, enable.
// ----------------------------------------------------------------------------
// Each accepted request (start or completed exchange) yields exactly one
// result, in the cycle after acceptance. The sequence state updates in the
// acceptance cycle through a single level of next-state logic, so one request
// is taken every clock; the result register stalls intake only while a result
// is held and out_ready is low. Registers: timeout_cycles at 0x0, max_attempts
// at 0x4, both reset to 3000 and 2; write them only while the block is idle.
// ----------------------------------------------------------------------------
module drive_enable_sequencer
  import des_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [15:0] in_status_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_control_word,
  output logic [2:0]       out_phase,
  output logic [2:0]       out_outcome,
  output logic [3:0]       out_attempt,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  seq_cfg_t   cfg_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  logic       out_valid_r;
  logic       in_acc;
  logic       cfg_wr;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT:  prdata = {16'd0, cfg_r.timeout_cycles};
      REG_ATTEMPTS: prdata = {28'd0, cfg_r.max_attempts};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_cycles <= TIMEOUT_RESET;
      cfg_r.max_attempts   <= ATTEMPTS_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_TIMEOUT) begin
        cfg_r.timeout_cycles <= pwdata[15:0];
      end else begin
        cfg_r.max_attempts <= pwdata[3:0];
      end
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  des_step u_step (
    .cur         (st_r),
    .cfg         (cfg_r),
    .operation   (in_operation),
    .status_word (in_status_word),
    .nxt         (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_IDLE;
      st_r.command_word <= CW_DISABLE_VOLTAGE;
      st_r.wait_count   <= 16'd0;
      st_r.attempt      <= 4'd0;
      st_r.outcome      <= OC_NONE;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // the state register doubles as the result register
  assign out_valid        = out_valid_r;
  assign out_control_word = st_r.command_word;
  assign out_phase        = phase_code(st_r.phase);
  assign out_outcome      = st_r.outcome;
  assign out_attempt      = st_r.attempt;

  a_running_has_attempt : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != PH_IDLE |-> st_r.attempt != 4'd0)
    else $error("sequence running with attempt zero");

  a_outcome_only_idle : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.outcome != OC_NONE |-> st_r.phase == PH_IDLE)
    else $error("final outcome reported while running");

  a_reset_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_RESET |-> st_r.command_word == CW_FAULT_RESET)
    else $error("fault reset phase without fault reset command");

  a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule
`default_nettype wire

// File: tb/drive_enable_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_enable_sequencer_tb
// Self-checking bench for the CiA402 bring-up sequencer. Start and exchange
// requests go in with random gaps and are scored against an in-bench model of
// the probe / fault reset / shutdown / switch on / enable sequence, across
// several timeout and attempt settings written over the register port.
// ----------------------------------------------------------------------------
module drive_enable_sequencer_tb;
  import des_pkg::*;

  typedef struct {
    logic [15:0] control_word;
    logic [2:0]  phase;
    logic [2:0]  outcome;
    logic [3:0]  attempt;
  } drive_reply_t;

  class bringup_scoreboard;
    logic [15:0]  timeout_cycles = TIMEOUT_RESET;
    logic [3:0]   max_attempts = ATTEMPTS_RESET;
    logic [2:0]   phase = PHC_IDLE;
    logic [15:0]  command_word = CW_DISABLE_VOLTAGE;
    logic [15:0]  wait_cnt = '0;
    logic [3:0]   attempt = '0;
    logic [2:0]   outcome = OC_NONE;
    drive_reply_t replies_due[$];
    int           failures = 0;
    int           checked = 0;
    int           requests = 0;
    int           retries = 0;
    int           runs_ended[8];

    function void enter_step(logic [2:0] ph, logic [15:0] cw);
      phase = ph;
      command_word = cw;
      wait_cnt = '0;
    endfunction

    // a timeout of zero expires on the first miss, like one
    function bit wait_exhausted();
      wait_cnt = wait_cnt + 16'd1;
      return (wait_cnt >= timeout_cycles) || (wait_cnt == 16'd0);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void note_request(logic op, logic [15:0] sw);
      drive_reply_t r;
      logic [2:0]   was;
      logic [15:0]  target;
      was = phase;
      requests++;
      if (op == OP_START) begin
        wait_cnt = '0;
        if (max_attempts == 4'd0) begin
          phase = PHC_IDLE;
          attempt = '0;
          outcome = OC_PERSISTENT;
          runs_ended[OC_PERSISTENT]++;
        end else begin
          phase = PHC_PROBE;
          attempt = 4'd1;
          outcome = OC_NONE;
        end
      end else begin
        case (phase)
          PHC_PROBE: begin
            if ((sw & SW_FAULT) != 0) enter_step(PHC_RESET, CW_FAULT_RESET);
            else enter_step(PHC_SHUT, CW_SHUTDOWN);
          end
          PHC_RESET: begin
            if ((sw & SW_FAULT) == 0) begin
              enter_step(PHC_SHUT, CW_SHUTDOWN);
            end else if (wait_exhausted()) begin
              phase = PHC_IDLE;
              command_word = CW_DISABLE_VOLTAGE;
              outcome = OC_RESET_TO;
            end
          end
          PHC_SHUT, PHC_SWON, PHC_ENABLE: begin
            target = (phase == PHC_SHUT) ? SW_READY :
                     (phase == PHC_SWON) ? SW_SWITCHED_ON : SW_OP_ENABLED;
            if ((sw & SW_STATE_MASK) == target) begin
              if (phase == PHC_SHUT) enter_step(PHC_SWON, CW_SWITCH_ON);
              else if (phase == PHC_SWON) enter_step(PHC_ENABLE, CW_ENABLE_OP);
              else begin
                phase = PHC_IDLE;
                outcome = OC_ENABLED;
              end
            end else if ((sw & SW_FAULT) != 0) begin
              // trip: retry from the probe with the step command still held
              if (attempt < max_attempts) begin
                attempt = attempt + 4'd1;
                phase = PHC_PROBE;
                wait_cnt = '0;
                retries++;
              end else begin
                phase = PHC_IDLE;
                outcome = OC_PERSISTENT;
              end
            end else if (wait_exhausted()) begin
              phase = PHC_IDLE;
              outcome = OC_STEP_TO;
            end
          end
          default: ;
        endcase
        if (was != PHC_IDLE && phase == PHC_IDLE) runs_ended[outcome]++;
      end
      r.control_word = command_word;
      r.phase = phase;
      r.outcome = outcome;
      r.attempt = attempt;
      replies_due.push_back(r);
    endfunction

    function void check_result(logic [15:0] cw, logic [2:0] ph, logic [2:0] oc,
                               logic [3:0] at);
      drive_reply_t want;
      if (replies_due.size() == 0) begin
        $error("result with no request pending: control_word %h", cw);
        failures++;
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (cw !== want.control_word) begin
        $error("control_word expected %h got %h", want.control_word, cw);
        failures++;
      end
      if (ph !== want.phase) begin
        $error("phase expected %0d got %0d", want.phase, ph);
        failures++;
      end
      if (oc !== want.outcome) begin
        $error("outcome expected %0d got %0d", want.outcome, oc);
        failures++;
      end
      if (at !== want.attempt) begin
        $error("attempt expected %0d got %0d", want.attempt, at);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_operation = OP_START;
  logic [15:0] in_status_word = '0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         in_ready;
  wire         out_valid;
  wire  [15:0] out_control_word;
  wire  [2:0]  out_phase;
  wire  [2:0]  out_outcome;
  wire  [3:0]  out_attempt;
  wire  [31:0] prdata;
  wire         pready;

  bringup_scoreboard sb = new();
  int gap_pct = 20;
  int stall_pct = 20;
  int settings_used = 1;

  drive_enable_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_status_word   (in_status_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_control_word (out_control_word),
    .out_phase        (out_phase),
    .out_outcome      (out_outcome),
    .out_attempt      (out_attempt),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("drive_enable_sequencer: mismatch");
    $finish;
  end

  // result side: score each accepted result, stall in random bursts
  always @(posedge clk) begin
    int stall_left;
    if (out_valid && out_ready)
      sb.check_result(out_control_word, out_phase, out_outcome, out_attempt);
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 13);
    out_ready <= (stall_left == 0);
  end

  task automatic offer_request(input logic op, input logic [15:0] sw);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_status_word <= sw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, sw);
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tmo, input logic [3:0] att);
    in_valid <= 1'b0;
    drain_results();
    repeat (3) @(posedge clk);
    write_reg({REG_TIMEOUT, 2'b00}, {16'h0, tmo});
    sb.timeout_cycles = tmo;
    write_reg({REG_ATTEMPTS, 2'b00}, {28'h0, att});
    sb.max_attempts = att;
    settings_used++;
  endtask

  // mostly well-formed status for the step being waited on, rest noise
  function automatic logic [15:0] pick_status(input logic [2:0] ph);
    logic [15:0] noise;
    logic [15:0] target;
    int          roll;
    noise = 16'($urandom);
    roll = $urandom_range(0, 99);
    case (ph)
      PHC_PROBE, PHC_RESET: begin
        return (roll < 45) ? (noise | SW_FAULT) : (noise & ~SW_FAULT);
      end
      PHC_SHUT, PHC_SWON, PHC_ENABLE: begin
        target = (ph == PHC_SHUT) ? SW_READY :
                 (ph == PHC_SWON) ? SW_SWITCHED_ON : SW_OP_ENABLED;
        if (roll < 55) return (noise & ~SW_STATE_MASK) | target;
        if (roll < 68) return noise | SW_FAULT;
        return noise;
      end
      default: return noise;
    endcase
  endfunction

  task automatic run_random(input int count, input int gap, input int stall);
    int          done;
    bit          paused;
    logic        op;
    logic [15:0] sw;
    gap_pct = gap;
    stall_pct = stall;
    done = 0;
    paused = 1'b0;
    while (done < count) begin
      if (sb.phase == PHC_IDLE)
        op = ($urandom_range(0, 99) < 85) ? OP_START : OP_EXCHANGE;
      else
        op = ($urandom_range(0, 99) < 2) ? OP_START : OP_EXCHANGE;
      if (op == OP_START || sb.phase != PHC_IDLE) done++;
      sw = pick_status(sb.phase);
      offer_request(op, sw);
      // hold off until the block has answered everything
      if (!paused && done >= count / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        drain_results();
      end
    end
  endtask

  initial begin
    logic [15:0] plan_timeout[8] = '{16'd3000, 16'd1, 16'd0, 16'd65535,
                                     16'd4, 16'd2, 16'd3, 16'd6};
    logic [3:0]  plan_attempts[8] = '{4'd2, 4'd1, 4'd15, 4'd15, 4'd3, 4'd0, 4'd2, 4'd4};
    int plan_items[8] = '{210, 190, 190, 210, 210, 40, 210, 210};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle exchange, fault reset, full bring-up with a trip,
    // persistent fault, restart in the middle of a run
    offer_request(OP_EXCHANGE, 16'hFFFF);
    offer_request(OP_START, 16'hFFFF);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_EXCHANGE, 16'h0000);
    offer_request(OP_EXCHANGE, SW_READY);
    offer_request(OP_EXCHANGE, SW_SWITCHED_ON);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_EXCHANGE, 16'h0000);
    offer_request(OP_EXCHANGE, 16'hFF90 | SW_READY);
    offer_request(OP_EXCHANGE, SW_SWITCHED_ON);
    offer_request(OP_EXCHANGE, SW_OP_ENABLED);
    offer_request(OP_START, 16'h0000);
    offer_request(OP_EXCHANGE, 16'h0000);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_EXCHANGE, 16'h0000);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_START, 16'h0000);
    offer_request(OP_EXCHANGE, 16'h0000);
    offer_request(OP_START, 16'hFFFF);

    // single-exchange waits: reset timeout, then step timeout
    set_config(16'd1, 4'd1);
    offer_request(OP_START, 16'h0000);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_EXCHANGE, SW_FAULT);
    offer_request(OP_START, 16'h0000);
    offer_request(OP_EXCHANGE, 16'h0000);
    offer_request(OP_EXCHANGE, 16'h0040);

    for (int p = 0; p < 8; p++) begin
      set_config(plan_timeout[p], plan_attempts[p]);
      if (p == 7) run_random(plan_items[p], 0, 0);
      else run_random(plan_items[p], $urandom_range(0, 2) * 15, $urandom_range(0, 2) * 15);
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d requests, %0d results scored over %0d register settings",
             sb.requests, sb.checked, settings_used);
    $display("runs: %0d enabled, %0d step timeout, %0d reset timeout, %0d fault, %0d retries",
             sb.runs_ended[OC_ENABLED], sb.runs_ended[OC_STEP_TO],
             sb.runs_ended[OC_RESET_TO], sb.runs_ended[OC_PERSISTENT], sb.retries);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("drive_enable_sequencer: match");
    end else begin
      $display("drive_enable_sequencer: mismatch");
    end
    $finish;
  end

endmodule
